FILE: hdl/remote_knob_smoother_with_link_fallback_top_macros.svh
// Assertion macros shared by the knob smoother RTL.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef REMOTE_KNOB_SMOOTHER_WITH_LINK_FALLBACK_TOP_MACROS_SVH
`define REMOTE_KNOB_SMOOTHER_WITH_LINK_FALLBACK_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RKSF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rksf check failed");
// next-cycle implication
`define RKSF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rksf check failed");
`else
`define RKSF_ASSERT_IMP(lbl, ante, cons)
`define RKSF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/rksf_pkg.sv
// Package for the knob smoother: widths, reset values, codes and helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rksf_pkg;

   localparam int VAL_W        = 20;   // value, raw units with 8 fraction bits
   localparam int CNT_W        = 16;   // ms counters and config registers
   localparam int RAW_W        = 12;
   localparam int CH_FIELD_W   = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int OPA_W        = 22;
   localparam int OPB_W        = 17;
   localparam int PROD_W       = OPA_W + OPB_W;
   localparam int SUM_W        = 24;
   localparam int DIV_NUM_W    = 37;
   localparam int GLIDE_Q_W    = 21;
   localparam int PKT_Q_W      = PROD_W - 16;

   localparam int CHANNELS_DEFAULT = 16;
   localparam int MAX_RESULTS      = 16;

   localparam logic [VAL_W-1:0] MID_SCALE = VAL_W'(524160);
   localparam logic [VAL_W-1:0] VAL_MAX   = '1;
   localparam logic [VAL_W-1:0] VAL_ZERO  = '0;
   localparam logic [CNT_W-1:0] CNT_MAX   = '1;

   localparam logic [CNT_W-1:0] GAIN_RESET     = CNT_W'(9830);
   localparam logic [CNT_W-1:0] SILENCE_RESET  = CNT_W'(1200);
   localparam logic [CNT_W-1:0] GLIDE_RESET    = CNT_W'(3000);
   localparam logic [CNT_W-1:0] LOCKOUT_RESET  = CNT_W'(200);

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_GAIN    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LIMIT_MS  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GLIDE_MS          = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_LOCKOUT_MS = CSR_IDX_W'(3);

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + CNT_W'(1);
   endfunction

   // base + delta, clamped to the value range
   function automatic logic [VAL_W-1:0] clamp_add(input logic [VAL_W-1:0] base,
                                                  input logic signed [SUM_W-1:0] delta);
      logic signed [SUM_W-1:0] sum;
      sum = $signed({{(SUM_W-VAL_W){1'b0}}, base}) + delta;
      if (sum < 0) begin
         return VAL_ZERO;
      end else if (sum > $signed({{(SUM_W-VAL_W){1'b0}}, VAL_MAX})) begin
         return VAL_MAX;
      end else begin
         return sum[VAL_W-1:0];
      end
   endfunction

endpackage

FILE: hdl/remote_knob_smoother_with_link_fallback_top.sv
// Knob smoother with link fallback: sequencer, shared multiplier and banks.
// Uses rksf_pkg, rksf_bank, rksf_div and the assertion macro header.
`timescale 1ns / 1ps
`include "remote_knob_smoother_with_link_fallback_top_macros.svh"

// Usage
//  req_* carries one transaction: a packet element (op 0) or a 1 ms tick (op 1).
//  It is taken when req_valid is high and req_stall low; req_stall is high
//  while an earlier transaction is still in work.
//  A packet element updates one channel by exponential averaging and makes no
//  result; it steps through read, operand, multiply and write back.
//  A tick walks all CHANNELS serially and emits one rsp_* transaction per
//  channel 0 .. min(CHANNELS,16)-1, last_of_tick on the final one.
//  Per channel, a running glide adds a pass through the 37-step restoring
//  divider shared by all channels.
//  The result sits in an output register; while rsp_stall is high the walk
//  waits on that register and the result holds.
//  csr_* writes a config register; write only while the block is idle.
//  Synchronous reset restores presets and values to mid-scale, config to
//  defaults and the link to never heard; no clearing pass is needed.

module remote_knob_smoother_with_link_fallback_top
   import rksf_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [CH_FIELD_W-1:0] req_channel,
   input  logic [RAW_W-1:0]      req_raw_value,
   input  logic                  req_packet_end,
   input  logic                  req_button_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_FIELD_W-1:0] rsp_out_channel,
   output logic [VAL_W-1:0]      rsp_smoothed,
   output logic                  rsp_link_alive,
   output logic                  rsp_preset_saved,
   output logic                  rsp_last_of_tick,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CNT_W-1:0]      csr_write_data
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NOUT = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_P_RD  = 11'b000_0000_0010,
      S_P_OPA = 11'b000_0000_0100,
      S_P_MUL = 11'b000_0000_1000,
      S_P_WB  = 11'b000_0001_0000,
      S_T_RD  = 11'b000_0010_0000,
      S_T_OPA = 11'b000_0100_0000,
      S_T_MUL = 11'b000_1000_0000,
      S_T_DST = 11'b001_0000_0000,
      S_T_DIV = 11'b010_0000_0000,
      S_T_OUT = 11'b100_0000_0000
   } state_type;

   // config registers
   logic [CNT_W-1:0] gain_ff, silence_ff, glide_ff, lockout_ff;

   // control state
   state_type        state_ff,         state_in;
   logic [CH_W-1:0]  addr_ff,          addr_in;
   logic [CNT_W-1:0] msp_ff,           msp_in;
   logic [CNT_W-1:0] mss_ff,           mss_in;
   logic [CNT_W-1:0] elapsed_ff,       elapsed_in;
   logic             heard_ff,         heard_in;
   logic             alive_before_ff,  alive_before_in;
   logic             button_before_ff, button_before_in;
   logic             alive_ff,         alive_in;
   logic             fall_ff,          fall_in;
   logic             glide_act_ff,     glide_act_in;
   logic             saved_ff,         saved_in;
   logic             wb_pending_ff,    wb_pending_in;
   logic             rsp_valid_ff,     rsp_valid_in;

   // payload
   logic [RAW_W-1:0]        raw_ff,  raw_in;
   logic signed [OPA_W-1:0] op_a_ff, op_a_in;
   logic signed [OPB_W-1:0] op_b_ff, op_b_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [VAL_W-1:0]        base_ff, base_in;
   logic [VAL_W-1:0]        val_ff,  val_in;
   logic [CH_FIELD_W-1:0]   rsp_ch_ff,    rsp_ch_in;
   logic [VAL_W-1:0]        rsp_val_ff,   rsp_val_in;
   logic                    rsp_alive_ff, rsp_alive_in;
   logic                    rsp_saved_ff, rsp_saved_in;
   logic                    rsp_last_ff,  rsp_last_in;

   // bank ports
   logic [VAL_W-1:0] s_rd, p_rd, o_rd;
   logic             s_we, p_we, o_we;
   logic [VAL_W-1:0] s_wdata;

   // divider
   logic                 div_start;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_NUM_W-1:0] div_quot;

   // datapath helpers
   logic [CNT_W-1:0]        g_eff;
   logic [PROD_W-1:0]       prod_mag;
   logic [PROD_W-1:0]       pkt_rnd;
   logic [PKT_Q_W-1:0]      pkt_q;
   logic signed [SUM_W-1:0] pkt_d;
   logic [VAL_W-1:0]        pkt_new;
   logic [GLIDE_Q_W-1:0]    glide_q;
   logic signed [SUM_W-1:0] glide_d;
   logic [VAL_W-1:0]        origin_eff;
   logic [CNT_W-1:0]        msp_inc, mss_inc;
   logic                    tick_alive, press;
   logic [CNT_W-1:0]        elapsed_base;
   logic [CH_W+CH_FIELD_W-1:0] ch_wide;
   logic [CH_W+CH_FIELD_W-1:0] addr_wide;
   logic                    ch_ok;
   logic                    slot_free;
   logic                    last_channel;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= GAIN_RESET;
         silence_ff <= SILENCE_RESET;
         glide_ff   <= GLIDE_RESET;
         lockout_ff <= LOCKOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SMOOTHING_GAIN:    gain_ff    <= csr_write_data;
            CSR_SILENCE_LIMIT_MS:  silence_ff <= csr_write_data;
            CSR_GLIDE_MS:          glide_ff   <= csr_write_data;
            CSR_BUTTON_LOCKOUT_MS: lockout_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // fixed-point arithmetic around the shared multiplier
   always_comb begin
      g_eff    = (glide_ff == '0) ? CNT_W'(1) : glide_ff;
      prod_mag = prod_ff[PROD_W-1] ? $unsigned(-prod_ff) : $unsigned(prod_ff);
      // packet: round(prod / 65536), halves away from zero
      pkt_rnd  = prod_mag + PROD_W'(32768);
      pkt_q    = pkt_rnd[PROD_W-1:16];
      pkt_d    = prod_ff[PROD_W-1] ? -$signed({1'b0, pkt_q}) : $signed({1'b0, pkt_q});
      pkt_new  = clamp_add(base_ff, pkt_d);
      // glide: round(|prod| / g) via (|prod| + g/2) / g
      div_num  = DIV_NUM_W'(prod_mag[35:0]) + DIV_NUM_W'(g_eff >> 1);
      glide_q  = div_quot[GLIDE_Q_W-1:0];
      glide_d  = prod_ff[PROD_W-1] ? -$signed({3'b000, glide_q})
                                   : $signed({3'b000, glide_q});
      origin_eff = fall_ff ? s_rd : o_rd;
   end

   // tick bookkeeping, evaluated at the tick accept
   always_comb begin
      msp_inc      = sat_inc(msp_ff);
      mss_inc      = sat_inc(mss_ff);
      tick_alive   = heard_ff && (msp_inc < silence_ff);
      press        = button_before_ff && !req_button_level && (mss_inc > lockout_ff);
      elapsed_base = (alive_before_ff && !tick_alive) ? '0 : elapsed_ff;
      ch_wide      = (CH_W + CH_FIELD_W)'(req_channel);
      addr_wide    = (CH_W + CH_FIELD_W)'(addr_ff);
      ch_ok        = (int'(req_channel) < CHANNELS);
      slot_free    = !rsp_valid_ff || !rsp_stall;
      last_channel = (int'(addr_ff) == CHANNELS - 1);
   end

   always_comb begin
      state_in         = state_ff;
      addr_in          = addr_ff;
      msp_in           = msp_ff;
      mss_in           = mss_ff;
      elapsed_in       = elapsed_ff;
      heard_in         = heard_ff;
      alive_before_in  = alive_before_ff;
      button_before_in = button_before_ff;
      alive_in         = alive_ff;
      fall_in          = fall_ff;
      glide_act_in     = glide_act_ff;
      saved_in         = saved_ff;
      wb_pending_in    = wb_pending_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      raw_in           = raw_ff;
      op_a_in          = op_a_ff;
      op_b_in          = op_b_ff;
      prod_in          = prod_ff;
      base_in          = base_ff;
      val_in           = val_ff;
      rsp_ch_in        = rsp_ch_ff;
      rsp_val_in       = rsp_val_ff;
      rsp_alive_in     = rsp_alive_ff;
      rsp_saved_in     = rsp_saved_ff;
      rsp_last_in      = rsp_last_ff;
      div_start        = 1'b0;
      s_we             = 1'b0;
      p_we             = 1'b0;
      o_we             = 1'b0;
      s_wdata          = val_ff;

      // commit of the channel's values happens on entry to S_T_OUT;
      // wb_pending marks that commit cycle
      if (wb_pending_ff) begin
         s_we          = glide_act_ff;
         p_we          = saved_ff;
         wb_pending_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               raw_in = req_raw_value;
               if (req_op == OP_PACKET) begin
                  addr_in = ch_wide[CH_W-1:0];
                  if (req_packet_end) begin
                     msp_in   = '0;
                     heard_in = 1'b1;
                  end
                  if (ch_ok) begin
                     state_in = S_P_RD;
                  end
               end else begin
                  addr_in          = '0;
                  msp_in           = msp_inc;
                  mss_in           = press ? '0 : mss_inc;
                  alive_in         = tick_alive;
                  fall_in          = alive_before_ff && !tick_alive;
                  glide_act_in     = heard_ff && !tick_alive;
                  saved_in         = press;
                  alive_before_in  = tick_alive;
                  button_before_in = req_button_level;
                  elapsed_in       = (heard_ff && !tick_alive) ? sat_inc(elapsed_base)
                                                               : elapsed_base;
                  state_in         = S_T_RD;
               end
            end
         end
         S_P_RD: begin
            state_in = S_P_OPA;
         end
         S_P_OPA: begin
            base_in  = s_rd;
            op_a_in  = $signed({2'b00, raw_ff, 8'h00}) - $signed({2'b00, s_rd});
            op_b_in  = $signed({1'b0, gain_ff});
            state_in = S_P_MUL;
         end
         S_P_MUL: begin
            prod_in  = op_a_ff * op_b_ff;
            state_in = S_P_WB;
         end
         S_P_WB: begin
            s_we     = 1'b1;
            s_wdata  = pkt_new;
            state_in = S_IDLE;
         end
         S_T_RD: begin
            state_in = S_T_OPA;
         end
         S_T_OPA: begin
            o_we    = fall_ff;
            base_in = origin_eff;
            if (!glide_act_ff) begin
               val_in        = s_rd;
               wb_pending_in = 1'b1;
               state_in      = S_T_OUT;
            end else if (elapsed_ff >= g_eff) begin
               val_in        = p_rd;
               wb_pending_in = 1'b1;
               state_in      = S_T_OUT;
            end else begin
               op_a_in  = $signed({2'b00, p_rd}) - $signed({2'b00, origin_eff});
               op_b_in  = $signed({1'b0, elapsed_ff});
               state_in = S_T_MUL;
            end
         end
         S_T_MUL: begin
            prod_in  = op_a_ff * op_b_ff;
            state_in = S_T_DST;
         end
         S_T_DST: begin
            div_start = 1'b1;
            state_in  = S_T_DIV;
         end
         S_T_DIV: begin
            if (div_done) begin
               val_in        = clamp_add(base_ff, glide_d);
               wb_pending_in = 1'b1;
               state_in      = S_T_OUT;
            end
         end
         S_T_OUT: begin
            // wait for the commit cycle before moving on; channels past the
            // reported range advance without a result
            if (!wb_pending_ff) begin
               if (int'(addr_ff) < NOUT) begin
                  if (slot_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_ch_in    = addr_wide[CH_FIELD_W-1:0];
                     rsp_val_in   = val_ff;
                     rsp_alive_in = alive_ff;
                     rsp_saved_in = saved_ff;
                     rsp_last_in  = (int'(addr_ff) == NOUT - 1);
                     if (last_channel) begin
                        state_in = S_IDLE;
                     end else begin
                        addr_in  = addr_ff + CH_W'(1);
                        state_in = S_T_RD;
                     end
                  end
               end else if (last_channel) begin
                  state_in = S_IDLE;
               end else begin
                  addr_in  = addr_ff + CH_W'(1);
                  state_in = S_T_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         addr_ff          <= '0;
         msp_ff           <= '0;
         mss_ff           <= CNT_MAX;
         elapsed_ff       <= '0;
         heard_ff         <= 1'b0;
         alive_before_ff  <= 1'b0;
         button_before_ff <= 1'b1;
         alive_ff         <= 1'b0;
         fall_ff          <= 1'b0;
         glide_act_ff     <= 1'b0;
         saved_ff         <= 1'b0;
         wb_pending_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         addr_ff          <= addr_in;
         msp_ff           <= msp_in;
         mss_ff           <= mss_in;
         elapsed_ff       <= elapsed_in;
         heard_ff         <= heard_in;
         alive_before_ff  <= alive_before_in;
         button_before_ff <= button_before_in;
         alive_ff         <= alive_in;
         fall_ff          <= fall_in;
         glide_act_ff     <= glide_act_in;
         saved_ff         <= saved_in;
         wb_pending_ff    <= wb_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff       <= raw_in;
      op_a_ff      <= op_a_in;
      op_b_ff      <= op_b_in;
      prod_ff      <= prod_in;
      base_ff      <= base_in;
      val_ff       <= val_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_saved_ff <= rsp_saved_in;
      rsp_last_ff  <= rsp_last_in;
   end

   rksf_bank #(
      .DEPTH     (CHANNELS),
      .RESET_VAL (MID_SCALE)
   ) u_smoothed_bank (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s_we),
      .wr_addr (addr_ff),
      .wr_data (s_wdata),
      .rd_addr (addr_ff),
      .rd_data (s_rd)
   );

   rksf_bank #(
      .DEPTH     (CHANNELS),
      .RESET_VAL (MID_SCALE)
   ) u_preset_bank (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (p_we),
      .wr_addr (addr_ff),
      .wr_data (val_ff),
      .rd_addr (addr_ff),
      .rd_data (p_rd)
   );

   rksf_bank #(
      .DEPTH     (CHANNELS),
      .RESET_VAL (VAL_ZERO)
   ) u_origin_bank (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (o_we),
      .wr_addr (addr_ff),
      .wr_data (s_rd),
      .rd_addr (addr_ff),
      .rd_data (o_rd)
   );

   rksf_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (g_eff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_ch_ff;
   assign rsp_smoothed     = rsp_val_ff;
   assign rsp_link_alive   = rsp_alive_ff;
   assign rsp_preset_saved = rsp_saved_ff;
   assign rsp_last_of_tick = rsp_last_ff;

   `RKSF_ASSERT_IMP(a_fall_implies_glide, fall_ff, glide_act_ff)
   `RKSF_ASSERT_IMP(a_alive_needs_heard, rsp_valid_ff && rsp_link_alive, heard_ff)
   `RKSF_ASSERT_IMP(a_div_done_in_wait, div_done, state_ff == S_T_DIV)
   `RKSF_ASSERT_IMP(a_save_clears_count, saved_ff && (state_ff != S_IDLE), mss_ff == '0)
   `RKSF_ASSERT_NXT(a_tick_starts_walk, (state_ff == S_IDLE) && req_valid && (req_op == OP_TICK), (state_ff == S_T_RD) && (addr_ff == '0))

endmodule

FILE: hdl/rksf_bank.sv
// Per-channel value store: one write port, one registered read port.
// Entries read as RESET_VAL until first written. Uses rksf_pkg.
`timescale 1ns / 1ps

module rksf_bank
   import rksf_pkg::*;
#(
   parameter int DEPTH = CHANNELS_DEFAULT,
   parameter logic [VAL_W-1:0] RESET_VAL = MID_SCALE,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [VAL_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [VAL_W-1:0]  rd_data
);

   logic [VAL_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [VAL_W-1:0] rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : RESET_VAL;
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rksf_div.sv
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per divide.
// Pulses done for one cycle when quot is valid. Uses rksf_pkg.
`timescale 1ns / 1ps

module rksf_div
   import rksf_pkg::*;
#(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = CNT_W,
   localparam int CNT_BITS = $clog2(NUM_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [DEN_W-1:0]    rem_ff,   rem_in;
   logic [NUM_W-1:0]    quot_ff,  quot_in;
   logic [DEN_W:0]      rem_sh;
   logic [DEN_W:0]      rem_diff;
   logic                ge;

   always_comb begin
      rem_sh   = {rem_ff, quot_ff[NUM_W-1]};
      rem_diff = rem_sh - {1'b0, den};
      ge       = (rem_sh >= {1'b0, den});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(NUM_W);
         rem_in   = '0;
         quot_in  = num;
      end else if (busy_ff) begin
         // shift the next dividend bit into the remainder, quotient bit out
         rem_in   = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quot_in  = {quot_ff[NUM_W-2:0], ge};
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
